>>> src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/astr_pkg.sv
// ----------------------------------------------------------------------------
// astr_pkg
// Shared constants and types for the adjacent swap tour refiner.
// ----------------------------------------------------------------------------
package astr_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W        = 16;
    localparam int INDEX_W        = 6;
    // Squared distance sum (three 17-bit differences squared), then the root.
    localparam int SQ_W           = 36;
    localparam int RAD_W          = SQ_W + 16;   // radicand after the shift
    localparam int ROOT_W         = RAD_W / 2;   // 26 bits
    localparam int SUM_W          = ROOT_W + 2;  // three roots added

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

endpackage

>>> src/astr_if.sv
// ----------------------------------------------------------------------------
// astr_in_if / astr_out_if
// Valid/ready channels for the point input and the index output.
// ----------------------------------------------------------------------------
interface astr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               last_point;
    modport source (output valid, pos_x, pos_y, pos_z, last_point, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, last_point, output ready);
endinterface

interface astr_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] point_index;
    logic       is_last;
    modport source (output valid, point_index, is_last, input ready);
    modport sink   (input valid, point_index, is_last, output ready);
endinterface

>>> src/astr_sqrt.sv
// ----------------------------------------------------------------------------
// astr_sqrt
// Shared restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module astr_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [astr_pkg::RAD_W-1:0]    i_rad,
    output logic [astr_pkg::ROOT_W-1:0]   o_root,
    output logic                          o_busy,
    output logic                          o_done
);
    import astr_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [ROOT_W+1:0] r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ROOT_W+1:0] w_trial;
    logic [ROOT_W+1:0] w_rem_sh;

    always_comb begin
        n_rad    = r_rad;
        n_rem    = r_rem;
        n_root   = r_root;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        w_rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
        w_trial  = {r_root, 2'b01};
        if (i_start && !r_busy) begin
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_W'(ROOT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[RAD_W-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                n_rem  = w_rem_sh - w_trial;
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_rem_sh;
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_root = r_root;
    assign o_busy = r_busy;
    assign o_done = r_done;

    `ASSERT_IMPL(a_done_ends_busy, i_clk, i_rst_n, !(r_done && r_busy), "sqrt done while busy")
    `ASSERT_IMPL(a_count_idle, i_clk, i_rst_n, !r_busy |-> r_cnt == '0, "sqrt count not zero idle")
    `ASSERT_IMPL(a_done_follows, i_clk, i_rst_n, r_done |-> $past(r_busy), "sqrt done without work")
endmodule

>>> src/astr_ctrl.sv
// ----------------------------------------------------------------------------
// astr_ctrl
// Sequencer: loads points, runs the swap pass with the shared root unit,
// then streams the tour order out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module astr_ctrl #(
    parameter int MAX_POINTS = astr_pkg::MAX_POINTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    astr_in_if.sink   in_ch,
    astr_out_if.source out_ch
);
    import astr_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_RDC   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_WAIT  = 4'd7;
    localparam logic [3:0] S_SWAP  = 4'd8;
    localparam logic [3:0] S_FLUSH = 4'd9;
    localparam logic [3:0] S_ERD   = 4'd10;
    localparam logic [3:0] S_EOUT  = 4'd11;

    // Point and order memories, read through registered ports.
    t_point            m_pts [MAX_POINTS];
    logic [AW-1:0]     m_ord [MAX_POINTS];

    logic [3:0]        r_state;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_pos;     // position i of the pass, or the emit position
    logic [2:0]        r_leg;     // leg 0..5 of the current position
    logic [AW-1:0]     r_ord [4]; // order entries i..i+3 held locally
    t_point            r_pa, r_pb;
    logic [SUM_W-1:0]  r_swp, r_kep;
    logic              r_ovalid;
    logic [AW-1:0]     r_oidx;
    logic              r_olast;
    logic [AW-1:0]     r_rd_ord;
    t_point            r_rd_pt;
    logic [SQ_W-1:0]   r_sq;

    logic              w_sq_start;
    logic              w_sq_busy;
    logic              w_sq_done;
    logic [ROOT_W-1:0] w_root;
    logic [RAD_W-1:0]  w_rad;
    logic [1:0]        w_sa, w_sb;
    logic [AW-1:0]     w_pt_addr;
    logic              w_out_free;
    logic              w_in_acc;
    logic              w_emit;
    logic              w_last_pos;
    logic              w_swap;

    // Leg endpoints within the window: swapped legs first, then kept legs.
    always_comb begin
        case (r_leg)
            3'd0:    begin w_sa = 2'd0; w_sb = 2'd2; end
            3'd1:    begin w_sa = 2'd2; w_sb = 2'd1; end
            3'd2:    begin w_sa = 2'd1; w_sb = 2'd3; end
            3'd3:    begin w_sa = 2'd0; w_sb = 2'd1; end
            3'd4:    begin w_sa = 2'd1; w_sb = 2'd2; end
            default: begin w_sa = 2'd2; w_sb = 2'd3; end
        endcase
    end

    function automatic logic [SQ_W-1:0] sq17(input logic signed [COORD_W-1:0] a,
                                             input logic signed [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        logic [SQ_W-1:0]  w;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? -d : d;
        w = SQ_W'(m);
        return w * w;
    endfunction

    // Squared distance of the two registered points; one multiplier per axis.
    always_ff @(posedge i_clk) begin
        r_sq <= sq17(r_pa.x, r_pb.x) + sq17(r_pa.y, r_pb.y) + sq17(r_pa.z, r_pb.z);
    end
    assign w_rad = {r_sq, 16'h0000};

    assign w_sq_start = (r_state == S_ROOT);
    astr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sq_start),
        .i_rad  (w_rad),
        .o_root (w_root),
        .o_busy (w_sq_busy),
        .o_done (w_sq_done)
    );

    assign w_out_free   = !r_ovalid || out_ch.ready;
    assign w_in_acc     = in_ch.valid && in_ch.ready;
    assign w_emit       = (r_state == S_EOUT) && w_out_free;
    assign w_last_pos   = (r_pos + CW'(1) >= r_cnt);
    assign w_swap       = (r_swp < r_kep);
    assign w_pt_addr    = (r_state == S_RDA) ? r_ord[w_sa] : r_ord[w_sb];
    assign in_ch.ready  = (r_state == S_LOAD);
    assign out_ch.valid       = r_ovalid;
    assign out_ch.point_index = INDEX_W'(r_oidx);
    assign out_ch.is_last     = r_olast;

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && r_cnt < CW'(MAX_POINTS)) begin
            m_pts[r_cnt[AW-1:0]] <= {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
        end
        if (r_state == S_INIT) begin
            m_ord[r_pos[AW-1:0]] <= r_pos[AW-1:0];
        end else if (r_state == S_SWAP || r_state == S_FLUSH) begin
            m_ord[r_pos[AW-1:0]] <= r_ord[0];
        end
        r_rd_ord <= m_ord[r_pos[AW-1:0]];
        if (r_state == S_RDA || r_state == S_RDB) begin
            r_rd_pt <= m_pts[w_pt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_leg    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_cnt < CW'(MAX_POINTS)) r_cnt <= r_cnt + CW'(1);
                        if (in_ch.last_point) begin
                            r_state <= S_INIT;
                            r_pos   <= '0;
                        end
                    end
                end
                S_INIT: begin
                    // Identity order, one entry a cycle.
                    if (w_last_pos) begin
                        r_pos   <= '0;
                        r_leg   <= '0;
                        r_state <= (r_cnt > CW'(3)) ? S_RDA : S_ERD;
                        r_swp   <= '0;
                        r_kep   <= '0;
                        // Window entries 0..3 are the identity here.
                        r_ord[0] <= AW'(0); r_ord[1] <= AW'(1);
                        r_ord[2] <= AW'(2); r_ord[3] <= AW'(3);
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_pa    <= r_rd_pt;
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_pb    <= r_rd_pt;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ROOT;
                S_ROOT: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_sq_done) begin
                        if (r_leg < 3'd3) r_swp <= r_swp + SUM_W'(w_root);
                        else              r_kep <= r_kep + SUM_W'(w_root);
                        if (r_leg == 3'd5) begin
                            r_state <= S_SWAP;
                        end else begin
                            r_leg   <= r_leg + 3'd1;
                            r_state <= S_RDA;
                        end
                    end
                end
                S_SWAP: begin
                    // Entry i is final; slide the window by one. Entries beyond the
                    // window have never moved, so the new last entry is i + 4.
                    r_ord[0] <= w_swap ? r_ord[2] : r_ord[1];
                    r_ord[1] <= w_swap ? r_ord[1] : r_ord[2];
                    r_ord[2] <= r_ord[3];
                    r_ord[3] <= AW'(r_pos + CW'(4));
                    r_swp <= '0;
                    r_kep <= '0;
                    r_leg <= '0;
                    r_pos <= r_pos + CW'(1);
                    r_state <= (r_pos + CW'(4) >= r_cnt) ? S_FLUSH : S_RDA;
                end
                S_FLUSH: begin
                    // Write the last three window entries back.
                    r_ord[0] <= r_ord[1];
                    r_ord[1] <= r_ord[2];
                    if (w_last_pos) begin
                        r_pos   <= '0;
                        r_state <= S_ERD;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
                S_ERD: r_state <= S_EOUT;
                S_EOUT: begin
                    if (w_out_free) begin
                        r_oidx  <= r_rd_ord;
                        r_olast <= w_last_pos;
                        if (w_last_pos) begin
                            r_state <= S_LOAD;
                            r_cnt   <= '0;
                            r_pos   <= '0;
                        end else begin
                            r_pos   <= r_pos + CW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_LOAD |-> !in_ch.ready, "input accepted during pass")
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_POINTS), "point count beyond capacity")
    `ASSERT_IMPL(a_root_once, i_clk, i_rst_n, w_sq_done |-> r_state == S_WAIT, "root result outside wait")
    `ASSERT_IMPL(a_root_idle, i_clk, i_rst_n, w_sq_start |-> !w_sq_busy, "root started while busy")
endmodule

>>> src/adjacent_swap_tour_refine.sv
// Points load one per cycle while the source is valid; the pass first writes the
// identity order one entry per cycle, then runs six legs per position through the
// shared 26-step root unit, and then writes the last three window entries back.
// Emission reads each entry, then sends its index; it waits while the sink stalls.
// Throughput: one path at a time; no new point is taken during pass or emission.
// Reset (synchronous, active low) clears the count, sequencer and output valid.
// ----------------------------------------------------------------------------
// adjacent_swap_tour_refine
// Top level: point load, one adjacent-swap pass, ordered index output.
// ----------------------------------------------------------------------------
module adjacent_swap_tour_refine #(
    parameter int MAX_POINTS = astr_pkg::MAX_POINTS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    astr_in_if.sink   in_ch,
    astr_out_if.source out_ch
);
    import astr_pkg::*;

    astr_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );
endmodule
